// ===== hw/rtl/lgge_pkg.sv =====
// ----------------------------------------------------------------------------
// lgge_pkg: shared types and constants of the life grid generation engine
// Holds the request kind codes and the B3/S23 neighbor-count thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package lgge_pkg;

  // Request kinds. Code 3 has no meaning and is dropped by the engine.
  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_STEP = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  // Width of a live-neighbor count (0 to 8).
  localparam int unsigned NBR_W = 4;

  // Rule B3/S23 thresholds.
  localparam logic [NBR_W-1:0] BIRTH_CNT  = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_LO = 4'd2;
  localparam logic [NBR_W-1:0] SURVIVE_HI = 4'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/lgge_ram.sv =====
// ----------------------------------------------------------------------------
// lgge_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and shows the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lgge_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lgge_row_rule.sv =====
// ----------------------------------------------------------------------------
// lgge_row_rule: next generation of one grid row
// Counts the eight neighbors of every cell from the rows above, at and below
// it and applies rule B3/S23. Cells past either end of a row count as dead.
// ----------------------------------------------------------------------------
`default_nettype none

module lgge_row_rule #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  wire logic [GRID_SIZE-1:0] above_i,
  input  wire logic [GRID_SIZE-1:0] mid_i,
  input  wire logic [GRID_SIZE-1:0] below_i,
  output logic      [GRID_SIZE-1:0] next_o
);

  // Rows padded with one dead cell at each end.
  logic [GRID_SIZE+1:0] above_p;
  logic [GRID_SIZE+1:0] mid_p;
  logic [GRID_SIZE+1:0] below_p;

  assign above_p = {1'b0, above_i, 1'b0};
  assign mid_p   = {1'b0, mid_i,   1'b0};
  assign below_p = {1'b0, below_i, 1'b0};

  // One small adder and compare per cell, all cells in parallel.
  for (genvar i = 0; i < GRID_SIZE; i++) begin : g_cell
    logic [lgge_pkg::NBR_W-1:0] nbr_cnt;

    assign nbr_cnt = lgge_pkg::NBR_W'(above_p[i])   + lgge_pkg::NBR_W'(above_p[i+1])
                   + lgge_pkg::NBR_W'(above_p[i+2]) + lgge_pkg::NBR_W'(mid_p[i])
                   + lgge_pkg::NBR_W'(mid_p[i+2])   + lgge_pkg::NBR_W'(below_p[i])
                   + lgge_pkg::NBR_W'(below_p[i+1]) + lgge_pkg::NBR_W'(below_p[i+2]);

    assign next_o[i] = mid_i[i] ? ((nbr_cnt == lgge_pkg::SURVIVE_LO) ||
                                   (nbr_cnt == lgge_pkg::SURVIVE_HI))
                                : (nbr_cnt == lgge_pkg::BIRTH_CNT);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/life_grid_generation_engine.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_engine: Conway's Game of Life grid, rule B3/S23
// Square grid of one-bit cells in a row-wide RAM, with set, step and read
// requests and a small output queue.
// ----------------------------------------------------------------------------
// Set and read requests are taken one per cycle while the input is not stalled;
// a read's result passes the registered RAM read and the second stage into the
// two-entry output queue, which lets requests keep flowing while a result waits.
// A step request holds the input stalled until the sweep is done: the grid RAM
// has one read port and a step sweeps it one row per cycle, computing each new
// row from a two-row window of old rows plus the row just read and writing it
// back in place. Reset needs no clearing pass: per-row valid flip-flops make
// rows never written read as dead.
`default_nettype none

module life_grid_generation_engine #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [5:0] cell_row_i,
  input  wire logic [5:0] cell_column_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            cell_alive_o
);

  localparam int unsigned ROW_W = $clog2(GRID_SIZE);
  localparam int unsigned CNT_W = $clog2(GRID_SIZE + 1);
  localparam logic [8:0]       GRID_LIM = 9'(GRID_SIZE);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GRID_SIZE);

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_e;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic             in_acc;
  logic             is_set;
  logic             is_step;
  logic             is_read;
  logic             in_grid;
  logic [ROW_W-1:0] req_row;
  logic [ROW_W-1:0] req_col;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign in_grid = (9'(cell_row_i) < GRID_LIM) && (9'(cell_column_i) < GRID_LIM);
  assign req_row = ROW_W'(cell_row_i);
  assign req_col = ROW_W'(cell_column_i);

  always_comb begin
    is_set  = 1'b0;
    is_step = 1'b0;
    is_read = 1'b0;
    case (lgge_pkg::kind_e'(kind_i))
      lgge_pkg::KIND_SET:  is_set  = 1'b1;
      lgge_pkg::KIND_STEP: is_step = 1'b1;
      lgge_pkg::KIND_READ: is_read = 1'b1;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Grid storage and row valid bits
  // --------------------------------------------------------------------------
  state_e             state_q;
  logic [CNT_W-1:0]   rd_row_q;
  logic               step_re;
  logic               ram_re;
  logic [ROW_W-1:0]   ram_raddr;
  logic [GRID_SIZE-1:0] ram_rdata;
  logic               ram_we;
  logic [ROW_W-1:0]   ram_waddr;
  logic [GRID_SIZE-1:0] ram_wdata;
  logic [GRID_SIZE-1:0] row_vld_q;

  assign step_re   = (state_q == ST_STEP) && (rd_row_q < LAST_CNT);
  assign ram_re    = step_re || (in_acc && (is_set || is_read));
  assign ram_raddr = (state_q == ST_STEP) ? rd_row_q[ROW_W-1:0] : req_row;

  lgge_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A row reads as dead until its first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (ram_we) begin
      row_vld_q[ram_waddr] <= 1'b1;
    end
  end

  // Last write, registered to cover a read issued in the same cycle as the write.
  logic                 wr_en_q;
  logic [ROW_W-1:0]     wr_addr_q;
  logic [GRID_SIZE-1:0] wr_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= ram_waddr;
    wr_data_q <= ram_wdata;
  end

  // --------------------------------------------------------------------------
  // Set and read pipeline: second stage after the RAM read
  // --------------------------------------------------------------------------
  logic                 s2_vld_q;
  logic                 s2_read_q;
  logic                 s2_inside_q;
  logic                 s2_rv_q;
  logic [ROW_W-1:0]     s2_row_q;
  logic [ROW_W-1:0]     s2_col_q;
  logic [GRID_SIZE-1:0] s2_old_row;
  logic                 s2_set_we;
  logic                 s2_push;
  logic                 s2_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= in_acc && ((is_set && in_grid) || is_read);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_read_q   <= is_read;
    s2_inside_q <= in_grid;
    s2_rv_q     <= in_grid && row_vld_q[req_row];
    s2_row_q    <= req_row;
    s2_col_q    <= req_col;
  end

  // Forward the row written in the read cycle, else use the RAM or dead row.
  always_comb begin
    if (wr_en_q && (wr_addr_q == s2_row_q)) begin
      s2_old_row = wr_data_q;
    end else if (s2_rv_q) begin
      s2_old_row = ram_rdata;
    end else begin
      s2_old_row = '0;
    end
  end

  assign s2_set_we = s2_vld_q && !s2_read_q;
  assign s2_push   = s2_vld_q && s2_read_q;
  assign s2_bit    = s2_inside_q && s2_old_row[s2_col_q];

  // --------------------------------------------------------------------------
  // Generation step: row sweep with a window of old rows
  // --------------------------------------------------------------------------
  logic                 arr_vld_q;
  logic [CNT_W-1:0]     arr_idx_q;
  logic                 arr_rv_q;
  logic [GRID_SIZE-1:0] win_prev_q;
  logic [GRID_SIZE-1:0] win_cur_q;
  logic [GRID_SIZE-1:0] arr_row;
  logic [GRID_SIZE-1:0] new_row;
  logic                 step_we;

  assign arr_row = arr_rv_q ? ram_rdata : '0;
  assign step_we = arr_vld_q && (arr_idx_q != '0);

  lgge_row_rule #(
    .GRID_SIZE (GRID_SIZE)
  ) u_row_rule (
    .above_i (win_prev_q),
    .mid_i   (win_cur_q),
    .below_i (arr_row),
    .next_o  (new_row)
  );

  // State, sweep counter, arrival tracking and window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_row_q   <= '0;
      arr_vld_q  <= 1'b0;
      arr_idx_q  <= '0;
      arr_rv_q   <= 1'b0;
      win_prev_q <= '0;
      win_cur_q  <= '0;
    end else begin
      arr_vld_q <= 1'b0;
      if (arr_vld_q) begin
        win_prev_q <= win_cur_q;
        win_cur_q  <= arr_row;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && is_step) begin
            state_q    <= ST_STEP;
            rd_row_q   <= '0;
            win_prev_q <= '0;
            win_cur_q  <= '0;
          end
        end
        ST_STEP: begin
          arr_vld_q <= 1'b1;
          arr_idx_q <= rd_row_q;
          arr_rv_q  <= step_re && row_vld_q[rd_row_q[ROW_W-1:0]];
          rd_row_q  <= rd_row_q + CNT_W'(1);
          if (rd_row_q == LAST_CNT) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Write port: step rows or a set, never both in one cycle.
  always_comb begin
    if (step_we) begin
      ram_we    = 1'b1;
      ram_waddr = ROW_W'(arr_idx_q - CNT_W'(1));
      ram_wdata = new_row;
    end else begin
      ram_we    = s2_set_we;
      ram_waddr = s2_row_q;
      ram_wdata = s2_old_row | (GRID_SIZE'(1) << s2_col_q);
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: two entries
  // --------------------------------------------------------------------------
  logic [1:0] fifo_cnt_q;
  logic       fifo_head_q;
  logic       fifo_tail_q;
  logic       fifo_pop;
  logic [1:0] occ;
  logic [1:0] occ_eff;

  assign fifo_pop = (fifo_cnt_q != 2'd0) && !out_stall_i;
  assign occ      = fifo_cnt_q + 2'(s2_push);
  assign occ_eff  = occ - 2'(fifo_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= 2'd0;
    end else begin
      fifo_cnt_q <= fifo_cnt_q + 2'(s2_push) - 2'(fifo_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_pop) begin
      fifo_head_q <= (fifo_cnt_q == 2'd2) ? fifo_tail_q : s2_bit;
      fifo_tail_q <= s2_bit;
    end else if (s2_push) begin
      if (fifo_cnt_q == 2'd0) begin
        fifo_head_q <= s2_bit;
      end else begin
        fifo_tail_q <= s2_bit;
      end
    end
  end

  assign out_valid_o  = (fifo_cnt_q != 2'd0);
  assign cell_alive_o = fifo_head_q;

  // Hold off requests during a step or when a new read result could not queue.
  assign in_stall_o = (state_q == ST_STEP) || occ_eff[1];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q != 2'd3)
    else $error("Output queue count out of range.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt_q == 2'd2) && s2_push |-> fifo_pop)
    else $error("Read result pushed into a full output queue.");

  a_write_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_we && s2_set_we))
    else $error("Step and set write the grid RAM in the same cycle.");

  a_step_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> !s2_vld_q)
    else $error("Set or read in flight during a generation step.");

  a_step_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) && (rd_row_q == LAST_CNT) |=>
      arr_vld_q && (arr_idx_q == LAST_CNT) && !arr_rv_q)
    else $error("Step sweep did not finish with the dead border row.");

endmodule

`default_nettype wire
